/* hdl/ptm_pkg.sv */
// Package for the pulse width trimmed mean block: sizes, trim limits and
// sequencer state type. No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

    localparam int SAMPLES   = 12;
    localparam int TIME_W    = 16;
    localparam int TRIM_LO   = SAMPLES / 3;
    localparam int TRIM_HI   = (SAMPLES * 2) / 3;
    localparam int TRIM_N    = (TRIM_HI - TRIM_LO == 0) ? 1 : TRIM_HI - TRIM_LO;
    localparam int IDX_W     = $clog2(SAMPLES);
    localparam int FILL_W    = $clog2(SAMPLES + 1);
    localparam int DEPTH     = 2 * SAMPLES;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SUM_W     = TIME_W + $clog2(TRIM_N + 1);
    // Divide by TRIM_N as a multiply by the rounded-up reciprocal and a shift;
    // exact for every dividend below 2**SUM_W.
    localparam int DIV_SHIFT = SUM_W + $clog2(TRIM_N);
    localparam int MUL_W     = SUM_W + 1;
    localparam int DIV_MUL   = ((1 << DIV_SHIFT) + TRIM_N - 1) / TRIM_N;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAB,
        ST_SCAN,
        ST_ACC,
        ST_DIV,
        ST_WAIT
    } t_state;

endpackage

`default_nettype wire

/* hdl/ptm_div.sv */
// Trimmed sum divided by the fixed trim count: one multiply by the rounded-up
// reciprocal and a shift, registered, so done rises in the cycle after start. Depends on ptm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptm_div
    import ptm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_dividend,
    output logic                   o_done,
    output logic [TIME_W-1:0]      o_quotient
);

    logic                     r_done;
    logic [TIME_W-1:0]        r_quo;
    logic [SUM_W+MUL_W-1:0]   product;

    assign product = {{MUL_W{1'b0}}, i_dividend} * {{SUM_W{1'b0}}, MUL_W'(DIV_MUL)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // Drop the fraction bits; the quotient always fits the width field.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= product[DIV_SHIFT +: TIME_W];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* hdl/pulse_width_trimmed_mean.sv */
// Top level of the pulse width trimmed mean block: capture handling, width
// memory, rank-and-sum sequencer. Depends on ptm_pkg and ptm_div.
`timescale 1ns / 1ps
`default_nettype none

// Each capture transfer (start high while busy is low) toggles its channel
// between latching a pulse start and storing a 16-bit wrapping pulse width.
// Rising-edge captures and widths that do not complete a batch never raise
// busy. The width that completes a batch of SAMPLES raises busy while the
// batch is reduced: every stored width is ranked against all the others
// through the single memory read port and one comparator, widths ranked in
// the middle third are summed, and the sum is divided by the trim count with
// one registered reciprocal multiply. Each width passes through load, grab, a
// scan over every stored width and accumulate, and the divide adds a start
// and a collect step; busy stays high until the quotient is collected. The
// result then appears in the first cycle with busy low, for exactly one cycle
// with o_result_valid high; the receiver cannot stall it, so sample the result
// ports in that cycle.
module pulse_width_trimmed_mean
    import ptm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_channel,
    input  wire logic [TIME_W-1:0] i_capture_time,
    output logic                   o_result_valid,
    output logic                   o_result_channel,
    output logic [TIME_W-1:0]      o_mean_width
);

    t_state r_state, n_state;

    // Per-channel capture state.
    logic [1:0]        r_await_rising;
    logic [TIME_W-1:0] r_start_time [2];
    logic [FILL_W-1:0] r_fill [2];

    // Width memory, both channels, one write and one registered read.
    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic              mem_we;

    // Sequencer datapath.
    logic              r_ch;
    logic [IDX_W-1:0]  r_i;
    logic [FILL_W-1:0] r_j;
    logic [TIME_W-1:0] r_vi;
    logic [IDX_W-1:0]  r_rank;
    logic [SUM_W-1:0]  r_sum;
    logic [ADDR_W-1:0] base;
    logic [FILL_W-1:0] cmp_idx;
    logic              cmp_less;

    logic              accept;
    logic              last_width;
    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_quo;

    logic              r_valid;
    logic              r_out_ch;
    logic [TIME_W-1:0] r_out_mean;

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign last_width = !r_await_rising[i_channel]
                        && (r_fill[i_channel] == FILL_W'(SAMPLES - 1));

    // Capture side: wrapping width goes straight into the next free slot.
    assign mem_we  = accept && !r_await_rising[i_channel];
    assign wr_data = i_capture_time - r_start_time[i_channel];
    assign wr_addr = (i_channel ? ADDR_W'(SAMPLES) : ADDR_W'(0))
                     + ADDR_W'(r_fill[i_channel][IDX_W-1:0]);

    assign base = r_ch ? ADDR_W'(SAMPLES) : ADDR_W'(0);

    always_comb begin
        if (r_state == ST_SCAN && r_j != FILL_W'(SAMPLES)) begin
            rd_addr = base + ADDR_W'(r_j[IDX_W-1:0]);
        end else begin
            rd_addr = base + ADDR_W'(r_i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Scan compare: data from index r_j-1 is on r_rd_data. Equal widths
    // break ties by position so every width gets a distinct rank.
    assign cmp_idx  = r_j - 1'b1;
    assign cmp_less = (r_rd_data < r_vi)
                      || ((r_rd_data == r_vi) && (cmp_idx < FILL_W'(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && last_width) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_GRAB;
            ST_GRAB: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_j == FILL_W'(SAMPLES)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (r_i == IDX_W'(SAMPLES - 1)) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_DIV: begin
                div_start = 1'b1;
                n_state   = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Capture control: hold the phase and fill count per channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await_rising  <= 2'b11;
            r_start_time[0] <= '0;
            r_start_time[1] <= '0;
            r_fill[0]       <= '0;
            r_fill[1]       <= '0;
        end else if (accept) begin
            r_await_rising[i_channel] <= !r_await_rising[i_channel];
            if (r_await_rising[i_channel]) begin
                r_start_time[i_channel] <= i_capture_time;
            end else if (last_width) begin
                r_fill[i_channel] <= '0;
            end else begin
                r_fill[i_channel] <= r_fill[i_channel] + 1'b1;
            end
        end
    end

    // Rank-and-sum datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_ch  <= i_channel;
                    r_i   <= '0;
                    r_sum <= '0;
                end
            end
            ST_GRAB: begin
                r_vi   <= r_rd_data;
                r_rank <= '0;
                r_j    <= '0;
            end
            ST_SCAN: begin
                r_j <= r_j + 1'b1;
                if (r_j != '0 && cmp_less) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            ST_ACC: begin
                // Keep only the widths that land in the middle third.
                if (r_rank >= IDX_W'(TRIM_LO) && r_rank < IDX_W'(TRIM_HI)) begin
                    r_sum <= r_sum + SUM_W'(r_vi);
                end
                r_i <= r_i + 1'b1;
            end
            default: begin
            end
        endcase
    end

    ptm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Result strobe: one cycle, no back-pressure.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_WAIT) && div_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WAIT && div_done) begin
            r_out_ch   <= r_ch;
            r_out_mean <= div_quo;
        end
    end

    assign o_result_valid   = r_valid;
    assign o_result_channel = r_out_ch;
    assign o_mean_width     = r_out_mean;

endmodule

`default_nettype wire
